FILE: rtl/core/dmc_pkg.sv
package dmc_pkg;

   // Fixed field widths of the request, response and control register.
   localparam int ADDR_WIDTH  = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int INDEX_WIDTH = 8;
   localparam int CSR_WIDTH   = 9;
   localparam int CSR_MAX     = (2 ** CSR_WIDTH) - 1;

   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 9'd256;

   // Default sizing of the top level.
   localparam int DEF_CACHE_LINES = 256;
   localparam int DEF_ADDR_BITS   = 16;

   // Quotient bits resolved by the remainder unit in each cycle.
   localparam int RADIX_BITS = 4;

   typedef enum logic [1:0] {
      OUTCOME_COLD     = 2'd0,
      OUTCOME_HIT      = 2'd1,
      OUTCOME_CONFLICT = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic        [ADDR_WIDTH-1:0] address;
      logic signed [WORD_WIDTH-1:0] mem_word;
   } dmc_req_type;

   typedef struct packed {
      outcome_type                   outcome;
      logic        [INDEX_WIDTH-1:0] line_index;
      logic signed [WORD_WIDTH-1:0]  data_out;
   } dmc_rsp_type;

endpackage

FILE: rtl/core/direct_mapped_cache_lookup.sv
// One item is worked on at a time; a new item is accepted only once the last result is out.
// The remainder unit resolves four address bits per cycle and is followed by a memory read
// step and an update step, which waits while the receiver still holds an earlier result.
// Reset is synchronous; afterwards a clearing pass over min(CACHE_LINES, 511) lines
// (256 by default) marks every line empty, and no item is accepted until it ends.
// Configuration writes are taken at any time, including during the clearing pass.
module direct_mapped_cache_lookup
   import dmc_pkg::*;
#(
   parameter int CACHE_LINES = DEF_CACHE_LINES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dmc_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dmc_rsp_type          rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_WIDTH-1:0] csr_write_data
);

   // The line count register cannot exceed CSR_MAX, so no line beyond that is ever
   // selected and the storage depth is capped there.
   localparam int DEPTH = (CACHE_LINES < CSR_MAX) ? CACHE_LINES : CSR_MAX;
   // Width of the line count and of the running remainder, which stays below it.
   localparam int NW    = $clog2(DEPTH + 1);
   // Width of a line index.
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Address bits that take part; the request field carries at most ADDR_WIDTH.
   localparam int AW    = (ADDR_BITS < ADDR_WIDTH) ? ADDR_BITS : ADDR_WIDTH;
   // Number of remainder steps and the zero-padded dividend width.
   localparam int STEPS = (AW + RADIX_BITS - 1) / RADIX_BITS;
   localparam int SW    = STEPS * RADIX_BITS;
   localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   // Control state.
   state_type            state_ff, state_in;
   logic [CW-1:0]        step_ff, step_in;
   logic [IW-1:0]        clr_ff, clr_in;
   logic [CSR_WIDTH-1:0] lines_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item payload held while it is worked on.
   logic [SW-1:0]         div_ff, div_in;
   logic [NW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   dmc_rsp_type           rsp_data_ff, rsp_data_in;

   // Line storage: valid flag, address tag and data word, with registered reads.
   logic                  valid_mem [DEPTH];
   logic [AW-1:0]         tag_mem   [DEPTH];
   logic [WORD_WIDTH-1:0] data_mem  [DEPTH];
   logic                  rd_valid_ff;
   logic [AW-1:0]         rd_tag_ff;
   logic [WORD_WIDTH-1:0] rd_data_ff;

   logic                  valid_we;
   logic                  valid_wdata;
   logic                  line_we;
   logic [IW-1:0]         mem_waddr;
   logic [IW-1:0]         line_idx;

   // Effective line count: zero counts as one, anything above the depth saturates.
   logic [31:0]           n_wide;
   logic [NW-1:0]         n_eff;
   // One radix step of the remainder unit.
   logic [NW-1:0]         rem_step;
   logic                  hit;
   logic [31:0]           idx_wide;

   assign line_idx = rem_ff[IW-1:0];
   assign idx_wide = 32'(line_idx);
   assign hit      = rd_valid_ff && (rd_tag_ff == addr_ff);

   always_comb begin
      if (lines_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(lines_ff) > DEPTH) begin
         n_wide = 32'(DEPTH);
      end else begin
         n_wide = 32'(lines_ff);
      end
      n_eff = n_wide[NW-1:0];
   end

   // Shift in the next four dividend bits, one conditional subtraction per bit.
   // The remainder is kept below the divisor, so the working value needs one more bit.
   always_comb begin
      logic [NW:0] r;
      r = {1'b0, rem_ff};
      for (int k = 0; k < RADIX_BITS; k++) begin
         r = {r[NW-1:0], div_ff[SW-1-k]};
         if (r >= {1'b0, n_ff}) begin
            r = r - {1'b0, n_ff};
         end
      end
      rem_step = r[NW-1:0];
   end

   // Sequencer: next state, datapath loads and memory write controls.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      addr_in      = addr_ff;
      word_in      = word_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      valid_we     = 1'b0;
      valid_wdata  = 1'b0;
      line_we      = 1'b0;
      mem_waddr    = line_idx;

      unique case (state_ff)
         ST_CLEAR: begin
            valid_we  = 1'b1;
            mem_waddr = clr_ff;
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               addr_in  = req_data.address[AW-1:0];
               word_in  = req_data.mem_word;
               div_in   = SW'(req_data.address[AW-1:0]);
               rem_in   = '0;
               n_in     = n_eff;
               step_in  = CW'(STEPS - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_step;
            div_in = div_ff << RADIX_BITS;
            if (step_ff == '0) begin
               state_in = ST_READ;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // Wait here while an earlier result is still held by the receiver.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.line_index = idx_wide[INDEX_WIDTH-1:0];
               if (hit) begin
                  rsp_data_in.outcome  = OUTCOME_HIT;
                  rsp_data_in.data_out = rd_data_ff;
               end else begin
                  rsp_data_in.outcome  = rd_valid_ff ? OUTCOME_CONFLICT : OUTCOME_COLD;
                  rsp_data_in.data_out = word_ff;
                  valid_we             = 1'b1;
                  valid_wdata          = 1'b1;
                  line_we              = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lines_ff     <= CSR_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            lines_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      n_ff        <= n_in;
      addr_ff     <= addr_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Line storage, one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[mem_waddr] <= valid_wdata;
      end
      if (line_we) begin
         tag_mem[mem_waddr]  <= addr_ff;
         data_mem[mem_waddr] <= word_ff;
      end
      if (state_ff == ST_READ) begin
         rd_valid_ff <= valid_mem[line_idx];
         rd_tag_ff   <= tag_mem[line_idx];
         rd_data_ff  <= data_mem[line_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The running remainder never reaches the divisor, so the line index stays in range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_READ) |-> (rem_ff < n_ff))
      else $error("remainder not below line count");

   // The divisor taken for an item is never zero and never beyond the storage depth.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (n_ff != '0 && 32'(n_ff) <= DEPTH))
      else $error("line count out of range");

   // A hit is reported only when the stored tag matched the item's address.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && state_in == ST_IDLE && rsp_data_in.outcome == OUTCOME_HIT)
         |-> (rd_valid_ff && rd_tag_ff == addr_ff))
      else $error("hit without matching tag");

   // Leaving the update step always presents a fresh result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("result lost on update");

endmodule

FILE: dv/tb_direct_mapped_cache_lookup.sv
`timescale 1ns / 1ps

module tb_direct_mapped_cache_lookup;
   import dmc_pkg::*;

   localparam int LINES = DEF_CACHE_LINES;

   // Every input of the block starts from a known value.
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   dmc_req_type          req_data       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   dmc_rsp_type          rsp_data;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_WIDTH-1:0] csr_write_data = '0;

   // Items waiting to be offered, and lookups whose results are still due.
   dmc_req_type lookup_queue[$];
   dmc_rsp_type predicted_results[$];
   logic [ADDR_WIDTH-1:0] recent_addresses[$];

   // Percentage of cycles in which each side holds back.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          mismatch_seen = 1'b0;

   // The testbench's own copy of the cache contents and of the line count register.
   bit                    cached_valid[LINES];
   logic [ADDR_WIDTH-1:0] cached_tag[LINES];
   logic [WORD_WIDTH-1:0] cached_word[LINES];
   logic [CSR_WIDTH-1:0]  line_count_reg = CSR_RESET;

   direct_mapped_cache_lookup dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   // Looks up one address in the local copy of the cache and updates it as the block
   // should. A line count of zero behaves as one line, and anything above the number of
   // physical lines is clamped to it. Because the full address is kept as the tag, a
   // line left over from an earlier line count can never give a wrong hit.
   function automatic dmc_rsp_type predict_lookup(input dmc_req_type item);
      dmc_rsp_type result;
      int unsigned lines_used;
      int unsigned slot;
      lines_used = line_count_reg;
      if (lines_used == 0)
         lines_used = 1;
      if (lines_used > LINES)
         lines_used = LINES;
      slot = int'(item.address) % lines_used;
      result.line_index = slot[INDEX_WIDTH-1:0];
      if (cached_valid[slot] && cached_tag[slot] == item.address) begin
         // On a hit the line stays as it is and the presented word is ignored.
         result.outcome  = OUTCOME_HIT;
         result.data_out = cached_word[slot];
      end else begin
         result.outcome    = cached_valid[slot] ? OUTCOME_CONFLICT : OUTCOME_COLD;
         result.data_out   = item.mem_word;
         cached_valid[slot] = 1'b1;
         cached_tag[slot]   = item.address;
         cached_word[slot]  = item.mem_word;
      end
      return result;
   endfunction

   // Driver. An item is offered whenever the previous one has gone (or nothing was on
   // offer) and the sender does not choose to idle; a stalled item is held unchanged.
   // The prediction is made at the very edge at which the block accepts the item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predicted_results.push_back(predict_lookup(req_data));
         if (!req_valid || !req_stall) begin
            if (lookup_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= lookup_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each result the block hands over is checked against the oldest lookup
   // still outstanding; the stall for the next cycle is drawn afresh every cycle.
   always @(posedge clock) begin
      dmc_rsp_type due;
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            $error("unexpected result: outcome %s, line_index %0d, data_out %0d",
                   rsp_data.outcome.name(), rsp_data.line_index, rsp_data.data_out);
            mismatch_seen = 1'b1;
         end else begin
            due = predicted_results.pop_front();
            if (rsp_data.outcome !== due.outcome) begin
               $error("outcome: expected %s, got %0d", due.outcome.name(), rsp_data.outcome);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.line_index !== due.line_index) begin
               $error("line_index: expected %0d, got %0d", due.line_index,
                      rsp_data.line_index);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.data_out !== due.data_out) begin
               $error("data_out: expected %0d, got %0d", due.data_out, rsp_data.data_out);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   task automatic add_lookup(input logic [ADDR_WIDTH-1:0] address,
                             input logic [WORD_WIDTH-1:0] mem_word);
      dmc_req_type item;
      item.address  = address;
      item.mem_word = mem_word;
      lookup_queue.push_back(item);
      recent_addresses.push_back(address);
      if (recent_addresses.size() > 24)
         void'(recent_addresses.pop_front());
   endtask

   // Most random traffic revisits recent addresses or stays within a narrow window, so
   // that hits and conflicts on the same lines are common; the rest is spread over the
   // whole address space.
   task automatic add_random_lookups(input int count);
      logic [ADDR_WIDTH-1:0] address;
      logic [WORD_WIDTH-1:0] mem_word;
      int unsigned           pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 45 && recent_addresses.size() != 0)
            address = recent_addresses[$urandom_range(recent_addresses.size() - 1)];
         else if (pick < 75)
            address = ADDR_WIDTH'($urandom_range(1023));
         else
            address = ADDR_WIDTH'($urandom_range(16'hFFFF));
         if ($urandom_range(9) == 0)
            mem_word = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else
            mem_word = $urandom();
         add_lookup(address, mem_word);
      end
   endtask

   // Waits until every item has been taken and every result has come back, then lets
   // the pipeline settle.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (lookup_queue.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // The line count is only changed while the block is idle, so the local copy can
   // follow it straight away.
   task automatic program_line_count(input logic [CSR_WIDTH-1:0] count);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      line_count_reg = count;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The sender idles rarely and the receiver often.
      send_idle_pct = 12;
      recv_idle_pct = 63;

      // With the reset line count: cold fills, hits that ignore the new word, and
      // conflicts at both ends of the address range and of the data range.
      add_lookup(16'h0000, 32'h7FFF_FFFF);
      add_lookup(16'h0000, 32'h0000_0000);
      add_lookup(16'hFFFF, 32'h8000_0000);
      add_lookup(16'h00FF, 32'hFFFF_FFFF);
      add_lookup(16'h00FF, 32'h1234_5678);
      add_lookup(16'h0100, 32'h0000_0000);
      add_lookup(16'h0000, 32'h5555_5555);
      wait_until_drained();

      // A line count of zero folds every address onto line 0; the contents are kept.
      program_line_count(9'd0);
      add_lookup(16'hFFFF, 32'hAAAA_AAAA);
      add_lookup(16'hFFFF, 32'h0F0F_0F0F);
      add_lookup(16'h1234, 32'hFFFF_FFFF);
      wait_until_drained();

      // An oversized count saturates at the number of lines. Line 0 still holds a tag
      // written under the old count, so address 0 must miss there.
      program_line_count(9'd511);
      add_lookup(16'h1234, 32'h8000_0000);
      add_lookup(16'h0134, 32'h7FFF_FFFF);
      add_lookup(16'hFFFF, 32'h0000_0001);
      add_lookup(16'h0000, 32'hFFFF_FFFF);
      add_lookup(16'h0000, 32'h0000_0000);
      wait_until_drained();

      program_line_count(9'd1);
      add_random_lookups(100);
      wait_until_drained();

      // The receiver now idles rarely and the sender often.
      send_idle_pct = 63;
      recv_idle_pct = 12;

      program_line_count(9'd255);
      add_random_lookups(150);
      wait_until_drained();

      program_line_count(9'd257);
      add_random_lookups(150);
      wait_until_drained();

      program_line_count(9'd37);
      add_random_lookups(150);
      wait_until_drained();

      // Neither side idles for the rest of the run.
      send_idle_pct = 0;
      recv_idle_pct = 0;

      program_line_count(9'd128);
      add_random_lookups(150);
      wait_until_drained();

      program_line_count(CSR_WIDTH'($urandom_range(2, CSR_MAX)));
      add_random_lookups(100);
      wait_until_drained();

      program_line_count(9'd256);
      add_random_lookups(100);
      wait_until_drained();

      repeat (10) @(posedge clock);
      if (!mismatch_seen && predicted_results.size() == 0) begin
         $display("direct_mapped_cache_lookup: match");
      end else begin
         $display("direct_mapped_cache_lookup: mismatch");
      end
      $finish;
   end

   // Far longer than the slowest correct run, clearing pass included.
   initial begin
      #(10_000_000);
      $display("direct_mapped_cache_lookup: mismatch");
      $finish;
   end

endmodule
